>>> hw/rtl/lic_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lic_pkg: shared types and constants of the interpolating color map
// Widths, register indexes, command codes, item structs and saturation.
// ----------------------------------------------------------------------------
package lic_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int VAL_W       = 32;
    localparam int FRAC_W      = 16;
    localparam int QUO_W       = ADDR_W + FRAC_W;
    localparam int SCALED_W    = VAL_W + ADDR_W;
    localparam int COUNT_W     = 11;
    localparam int WIDE_W      = 51;
    localparam int CFG_IDX_W   = 3;
    localparam int IN_TDATA_W  = 208;
    localparam int OUT_TDATA_W = 96;

    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NEAREST_MODE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_MODE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_TABLE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LUMINANCE_OUT = 3'd6;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic [FRAC_W:0]   HALF_WEIGHT = 17'd32768;
    localparam logic [FRAC_W:0]   FULL_WEIGHT = 17'd65536;
    localparam logic [FRAC_W-1:0] LUM_R = 16'd13938;
    localparam logic [FRAC_W-1:0] LUM_G = 16'd46868;
    localparam logic [FRAC_W-1:0] LUM_B = 16'd4730;

    typedef logic signed [VAL_W-1:0] t_val;

    typedef struct packed {
        t_val              low;
        t_val              high;
        logic [VAL_W-1:0]  span;
        logic [ADDR_W-1:0] n1;
        logic              nearest;
        logic              curve;
        logic              color;
        logic              lum;
        logic              err;
    } t_cfg;

    typedef struct packed {
        logic              wr;
        logic [ADDR_W-1:0] index;
        t_val [2:0]        wdata;
        t_val [2:0]        xc;
    } t_item;

    // Saturate a wide signed value to the signed 32 bit range.
    function automatic t_val sat_val(input logic signed [WIDE_W-1:0] v);
        logic same;
        same = (&v[WIDE_W-1:VAL_W-1]) | ~(|v[WIDE_W-1:VAL_W-1]);
        if (same) begin
            return v[VAL_W-1:0];
        end else if (v[WIDE_W-1]) begin
            return {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            return {1'b0, {(VAL_W-1){1'b1}}};
        end
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/lic_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lic_ram: generic single write port, single read port RAM
// Write and read in the same cycle; the read data is registered.
// ----------------------------------------------------------------------------
module lic_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

>>> hw/rtl/lic_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lic_front: command classification and input clamping
// Sorts a beat into table write or lookup and clamps the samples to range.
// ----------------------------------------------------------------------------
module lic_front (
    input  wire lic_pkg::t_cfg                    i_cfg,
    input  wire logic                             i_cmd,
    input  wire logic [lic_pkg::ADDR_W-1:0]       i_index,
    input  wire lic_pkg::t_val [2:0]              i_entry,
    input  wire lic_pkg::t_val [2:0]              i_sample,
    output lic_pkg::t_item                        o_item
);
    import lic_pkg::*;

    always_comb begin
        t_val x;
        o_item.wr    = (i_cmd == CMD_WRITE);
        o_item.index = i_index;
        o_item.wdata = i_entry;
        for (int k = 0; k < 3; k++) begin
            // Outside curve mode every channel maps the scalar input.
            x = i_cfg.curve ? i_sample[k] : i_sample[0];
            if ($signed(x) < $signed(i_cfg.low)) begin
                o_item.xc[k] = i_cfg.low;
            end else if ($signed(x) > $signed(i_cfg.high)) begin
                o_item.xc[k] = i_cfg.high;
            end else begin
                o_item.xc[k] = x;
            end
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/lic_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lic_queue: two-entry queue between front and back
// Lets the front keep accepting beats while the back is stalled.
// ----------------------------------------------------------------------------
module lic_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire lic_pkg::t_item i_item,
    output logic                o_ready,
    input  wire logic           i_pop,
    output logic                o_valid,
    output lic_pkg::t_item      o_item
);
    import lic_pkg::*;

    t_item      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/lic_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lic_back: lookup pipeline
// Scale, pipelined index division, table read, blend, luminance and output.
// ----------------------------------------------------------------------------
module lic_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire lic_pkg::t_cfg       i_cfg,
    input  wire logic                i_head_valid,
    input  wire lic_pkg::t_item      i_head,
    output logic                     o_pop,
    input  wire logic                i_m_ready,
    output logic                     o_m_valid,
    output lic_pkg::t_val [2:0]      o_result,
    output logic                     o_setup_error
);
    import lic_pkg::*;

    localparam int DIV_STAGES = QUO_W;

    typedef struct packed {
        logic              v;
        logic              wr;
        logic [ADDR_W-1:0] index;
        t_val [2:0]        wdata;
    } t_tag;

    typedef struct packed {
        t_tag                       tag;
        logic [2:0][VAL_W-1:0]      rem;
        logic [2:0][QUO_W-1:0]      num;
        logic [2:0][QUO_W-1:0]      quo;
    } t_div;

    // One quotient bit per channel: shift in a dividend bit, compare, subtract.
    function automatic t_div div_step(input t_div d, input logic [VAL_W-1:0] span);
        t_div           o;
        logic [VAL_W:0] t;
        logic           ge;
        o = d;
        for (int k = 0; k < 3; k++) begin
            t          = {d.rem[k], d.num[k][QUO_W-1]};
            ge         = (t >= {1'b0, span});
            o.rem[k]   = ge ? (t[VAL_W-1:0] - span) : t[VAL_W-1:0];
            o.num[k]   = {d.num[k][QUO_W-2:0], 1'b0};
            o.quo[k]   = {d.quo[k][QUO_W-2:0], ge};
        end
        return o;
    endfunction

    logic en;

    t_tag                     r_s1_tag;
    logic [2:0][VAL_W-1:0]    r_s1_d;
    t_tag                     r_s2_tag;
    logic [2:0][SCALED_W-1:0] r_s2_scaled;
    t_div                     dv_init;
    t_div                     r_dv [DIV_STAGES];
    t_div                     n_dv [DIV_STAGES];

    logic [2:0][ADDR_W-1:0]   addr_a;
    logic [2:0][ADDR_W-1:0]   addr_b;
    logic [2:0][FRAC_W:0]     weight;
    logic                     ram_we;
    logic [2:0][2*VAL_W-1:0]  ram_wdata;
    logic [2:0][2*VAL_W-1:0]  ram_a;
    logic [2:0][2*VAL_W-1:0]  ram_b;

    logic                     r_r_valid;
    logic [2:0][FRAC_W:0]     r_r_w;

    logic                     r_p1_valid;
    t_val [2:0]               r_p1_a;
    logic [2:0][VAL_W:0]      r_p1_diff;
    logic [2:0][FRAC_W:0]     r_p1_w;
    t_val [2:0]               r_p1_near;

    logic                     r_p2_valid;
    t_val [2:0]               r_p2_a;
    logic [2:0][WIDE_W-1:0]   r_p2_prod;
    t_val [2:0]               r_p2_near;

    logic                     r_p3_valid;
    t_val [2:0]               r_p3_res;

    logic                     r_l1_valid;
    t_val [2:0]               r_l1_res;
    logic [2:0][WIDE_W-1:0]   r_l1_lp;

    logic                     r_out_valid;
    t_val [2:0]               r_out_res;
    logic                     r_out_err;

    assign en    = !r_out_valid || i_m_ready;
    assign o_pop = en && i_head_valid;

    // Offset from range_low, then scale by entry_count - 1.
    always_ff @(posedge i_clk) begin
        logic [VAL_W:0] diff;
        if (!i_rst_n) begin
            r_s1_tag.v <= 1'b0;
            r_s2_tag.v <= 1'b0;
        end else if (en) begin
            r_s1_tag.v     <= o_pop;
            r_s1_tag.wr    <= i_head.wr;
            r_s1_tag.index <= i_head.index;
            r_s1_tag.wdata <= i_head.wdata;
            for (int k = 0; k < 3; k++) begin
                diff = {i_head.xc[k][VAL_W-1], i_head.xc[k]}
                     - {i_cfg.low[VAL_W-1], i_cfg.low};
                r_s1_d[k] <= diff[VAL_W-1:0];
            end
            r_s2_tag <= r_s1_tag;
            for (int k = 0; k < 3; k++) begin
                r_s2_scaled[k] <= SCALED_W'(r_s1_d[k]) * SCALED_W'(i_cfg.n1);
            end
        end
    end

    // The scaled value shifted up by the fraction width is divided by the
    // span; the quotient holds the entry index above the Q0.16 weight.
    always_comb begin
        dv_init.tag = r_s2_tag;
        for (int k = 0; k < 3; k++) begin
            dv_init.rem[k] = r_s2_scaled[k][SCALED_W-1:ADDR_W];
            dv_init.num[k] = {r_s2_scaled[k][ADDR_W-1:0], {FRAC_W{1'b0}}};
            dv_init.quo[k] = '0;
        end
        n_dv[0] = div_step(dv_init, i_cfg.span);
        for (int s = 1; s < DIV_STAGES; s++) begin
            n_dv[s] = div_step(r_dv[s-1], i_cfg.span);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_dv[s].tag.v <= 1'b0;
            end
        end else if (en) begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_dv[s] <= n_dv[s];
            end
        end
    end

    // Valid bits of the stages after the divider.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_valid   <= 1'b0;
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_p3_valid  <= 1'b0;
            r_l1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_r_valid   <= r_dv[DIV_STAGES-1].tag.v && !r_dv[DIV_STAGES-1].tag.wr;
            r_p1_valid  <= r_r_valid;
            r_p2_valid  <= r_p1_valid;
            r_p3_valid  <= r_p2_valid;
            r_l1_valid  <= r_p3_valid;
            r_out_valid <= r_l1_valid;
        end
    end

    // Index fix-up at the top end: an input at range_high lands on the last
    // pair with full weight.
    always_comb begin
        logic [ADDR_W-1:0] idx;
        for (int k = 0; k < 3; k++) begin
            idx = r_dv[DIV_STAGES-1].quo[k][QUO_W-1:FRAC_W];
            if (idx == i_cfg.n1) begin
                addr_a[k] = i_cfg.n1 - 1'b1;
                weight[k] = FULL_WEIGHT;
            end else begin
                addr_a[k] = idx;
                weight[k] = {1'b0, r_dv[DIV_STAGES-1].quo[k][FRAC_W-1:0]};
            end
            addr_b[k]    = addr_a[k] + 1'b1;
            ram_wdata[k] = {r_dv[DIV_STAGES-1].tag.wdata[k], r_dv[DIV_STAGES-1].tag.wdata[0]};
        end
        ram_we = en && r_dv[DIV_STAGES-1].tag.v && r_dv[DIV_STAGES-1].tag.wr;
    end

    // Each lane keeps its own column beside column zero, once for the lower
    // and once for the upper neighbor.
    for (genvar k = 0; k < 3; k++) begin : g_lane
        lic_ram #(.WIDTH(2 * VAL_W), .DEPTH(MAX_ENTRIES)) u_ram_a (
            .i_clk   (i_clk),
            .i_we    (ram_we),
            .i_waddr (r_dv[DIV_STAGES-1].tag.index),
            .i_wdata (ram_wdata[k]),
            .i_re    (en),
            .i_raddr (addr_a[k]),
            .o_rdata (ram_a[k])
        );
        lic_ram #(.WIDTH(2 * VAL_W), .DEPTH(MAX_ENTRIES)) u_ram_b (
            .i_clk   (i_clk),
            .i_we    (ram_we),
            .i_waddr (r_dv[DIV_STAGES-1].tag.index),
            .i_wdata (ram_wdata[k]),
            .i_re    (en),
            .i_raddr (addr_b[k]),
            .o_rdata (ram_b[k])
        );
    end

    always_ff @(posedge i_clk) begin
        t_val                    a;
        t_val                    b;
        logic signed [WIDE_W-1:0] dext;
        logic signed [WIDE_W-1:0] wext;
        logic signed [WIDE_W-1:0] sh;
        logic signed [WIDE_W-1:0] sum;
        logic signed [WIDE_W-1:0] rext;
        logic signed [WIDE_W-1:0] lsum;
        t_val                    lum;
        if (en) begin
            r_r_w <= weight;
            for (int k = 0; k < 3; k++) begin
                a = i_cfg.color ? ram_a[k][2*VAL_W-1:VAL_W] : ram_a[k][VAL_W-1:0];
                b = i_cfg.color ? ram_b[k][2*VAL_W-1:VAL_W] : ram_b[k][VAL_W-1:0];
                r_p1_a[k]    <= a;
                r_p1_diff[k] <= {b[VAL_W-1], b} - {a[VAL_W-1], a};
                r_p1_near[k] <= (r_r_w[k] < HALF_WEIGHT) ? a : b;
            end
            r_p1_w <= r_r_w;

            r_p2_a    <= r_p1_a;
            r_p2_near <= r_p1_near;
            for (int k = 0; k < 3; k++) begin
                dext = {{(WIDE_W-VAL_W-1){r_p1_diff[k][VAL_W]}}, r_p1_diff[k]};
                wext = {{(WIDE_W-FRAC_W-1){1'b0}}, r_p1_w[k]};
                r_p2_prod[k] <= dext * wext;
            end

            for (int k = 0; k < 3; k++) begin
                sh  = ($signed(r_p2_prod[k]) + $signed(WIDE_W'(HALF_WEIGHT))) >>> FRAC_W;
                sum = {{(WIDE_W-VAL_W){r_p2_a[k][VAL_W-1]}}, r_p2_a[k]} + sh;
                r_p3_res[k] <= i_cfg.nearest ? r_p2_near[k] : sat_val(sum);
            end

            r_l1_res <= r_p3_res;
            rext = {{(WIDE_W-VAL_W){r_p3_res[0][VAL_W-1]}}, r_p3_res[0]};
            r_l1_lp[0] <= rext * $signed({{(WIDE_W-FRAC_W){1'b0}}, LUM_R});
            rext = {{(WIDE_W-VAL_W){r_p3_res[1][VAL_W-1]}}, r_p3_res[1]};
            r_l1_lp[1] <= rext * $signed({{(WIDE_W-FRAC_W){1'b0}}, LUM_G});
            rext = {{(WIDE_W-VAL_W){r_p3_res[2][VAL_W-1]}}, r_p3_res[2]};
            r_l1_lp[2] <= rext * $signed({{(WIDE_W-FRAC_W){1'b0}}, LUM_B});

            lsum = ($signed(r_l1_lp[0]) + $signed(r_l1_lp[1]) + $signed(r_l1_lp[2])
                    + $signed(WIDE_W'(HALF_WEIGHT))) >>> FRAC_W;
            lum  = sat_val(lsum);
            r_out_err <= i_cfg.err;
            if (i_cfg.err) begin
                r_out_res <= '0;
            end else if (i_cfg.lum) begin
                r_out_res[0] <= lum;
                r_out_res[1] <= '0;
                r_out_res[2] <= '0;
            end else begin
                r_out_res <= r_l1_res;
            end
        end
    end

    assign o_m_valid     = r_out_valid;
    assign o_result      = r_out_res;
    assign o_setup_error = r_out_err;
endmodule
`default_nettype wire

>>> hw/rtl/lut_interpolate_color_map.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lut_interpolate_color_map: one-dimensional table lookup with interpolation
// Scalar color map or per-channel curves over a table of Q15.16 entries.
// ----------------------------------------------------------------------------
// The block takes one beat per clock unless back-pressure from the output
// holds it, and returns one result beat per lookup beat (table write beats
// return nothing), in order. Behind the offset and scale stages lies the index
// divider, a 26-stage pipeline that makes one quotient bit per stage for each
// of the three channels, followed by the registered table read, a three-stage
// blend, the luminance stage and the output register. Table writes travel the
// same pipeline and update the table where lookups read it, so every lookup
// sees exactly the writes accepted before it. Configuration is written through
// the plain write port while no beats are in flight; a lookup that reads a
// table slot never written holds undefined values in the affected channels.
// ----------------------------------------------------------------------------
module lut_interpolate_color_map (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Configuration write port.
    input  wire logic                            i_cfg_we,
    input  wire logic [lic_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [lic_pkg::VAL_W-1:0]       i_cfg_data,
    // Input stream.
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // tdata from bit 0: entry_index, entry_ch0, entry_ch1, entry_ch2,
    // sample_ch0, sample_ch1, sample_ch2, zero fill.
    input  wire logic [lic_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // tuser: command.
    input  wire logic                            i_s_axis_tuser,
    // Output stream.
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // tdata from bit 0: result_ch0, result_ch1, result_ch2.
    output logic [lic_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata,
    // tuser: setup_error.
    output logic                                 o_m_axis_tuser
);
    import lic_pkg::*;

    t_val               r_range_low;
    t_val               r_range_high;
    logic [COUNT_W-1:0] r_entry_count;
    logic               r_nearest_mode;
    logic               r_curve_mode;
    logic               r_color_table;
    logic               r_luminance_out;

    // Quantities derived from the registers are registered once; they are
    // first needed several stages into the pipeline.
    logic [VAL_W-1:0]   r_span;
    logic [ADDR_W-1:0]  r_n1;
    logic               r_err;

    t_cfg               cfg;
    t_item              front_item;
    t_item              head_item;
    logic               q_ready;
    logic               q_valid;
    logic               pop;
    logic               push;
    t_val [2:0]         entry;
    t_val [2:0]         sample;
    t_val [2:0]         result;
    logic               setup_error;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_low     <= '0;
            r_range_high    <= 32'sd65536;
            r_entry_count   <= 11'd2;
            r_nearest_mode  <= 1'b0;
            r_curve_mode    <= 1'b0;
            r_color_table   <= 1'b0;
            r_luminance_out <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_RANGE_LOW:     r_range_low     <= i_cfg_data;
                REG_RANGE_HIGH:    r_range_high    <= i_cfg_data;
                REG_ENTRY_COUNT:   r_entry_count   <= i_cfg_data[COUNT_W-1:0];
                REG_NEAREST_MODE:  r_nearest_mode  <= i_cfg_data[0];
                REG_CURVE_MODE:    r_curve_mode    <= i_cfg_data[0];
                REG_COLOR_TABLE:   r_color_table   <= i_cfg_data[0];
                REG_LUMINANCE_OUT: r_luminance_out <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        logic [COUNT_W-1:0] n1_full;
        n1_full = r_entry_count - 1'b1;
        r_span  <= r_range_high - r_range_low;
        r_n1    <= n1_full[ADDR_W-1:0];
        r_err   <= !($signed(r_range_high) > $signed(r_range_low))
                || (r_entry_count < COUNT_W'(2))
                || (r_entry_count > COUNT_W'(MAX_ENTRIES));
    end

    always_comb begin
        cfg.low     = r_range_low;
        cfg.high    = r_range_high;
        cfg.span    = r_span;
        cfg.n1      = r_n1;
        cfg.nearest = r_nearest_mode;
        cfg.curve   = r_curve_mode;
        cfg.color   = r_color_table;
        cfg.lum     = r_luminance_out;
        cfg.err     = r_err;
    end

    assign entry[0]  = i_s_axis_tdata[41:10];
    assign entry[1]  = i_s_axis_tdata[73:42];
    assign entry[2]  = i_s_axis_tdata[105:74];
    assign sample[0] = i_s_axis_tdata[137:106];
    assign sample[1] = i_s_axis_tdata[169:138];
    assign sample[2] = i_s_axis_tdata[201:170];

    assign o_s_axis_tready = q_ready;
    assign push            = i_s_axis_tvalid && q_ready;

    lic_front u_front (
        .i_cfg    (cfg),
        .i_cmd    (i_s_axis_tuser),
        .i_index  (i_s_axis_tdata[ADDR_W-1:0]),
        .i_entry  (entry),
        .i_sample (sample),
        .o_item   (front_item)
    );

    lic_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (head_item)
    );

    lic_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_head_valid  (q_valid),
        .i_head        (head_item),
        .o_pop         (pop),
        .i_m_ready     (i_m_axis_tready),
        .o_m_valid     (o_m_axis_tvalid),
        .o_result      (result),
        .o_setup_error (setup_error)
    );

    assign o_m_axis_tdata = {result[2], result[1], result[0]};
    assign o_m_axis_tuser = setup_error;
endmodule
`default_nettype wire
